FILE: hdl/baro_sensor_compensation_core_assert.svh
// assertion macros for the barometer compensation core
// no dependencies; included by baro_sensor_compensation_core, which checks its own logic
`ifndef BARO_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/baro_comp_pkg.sv
// types and constants of the barometer compensation core
// no dependencies; imported by baro_sensor_compensation_core
package baro_comp_pkg;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [18:0] temperature;
        logic signed [31:0] pressure;
        logic               pressure_negative;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_SENS_COEF      = 3'd0,
        CFG_OFF_COEF       = 3'd1,
        CFG_SENS_TEMP_COEF = 3'd2,
        CFG_OFF_TEMP_COEF  = 3'd3,
        CFG_REF_TEMP       = 3'd4,
        CFG_TEMP_SLOPE     = 3'd5
    } cfg_reg_t;

    localparam logic signed [18:0] TEMP_REF      = 19'sd2000;
    localparam logic signed [18:0] TEMP_VERY_LOW = -19'sd1500;
    localparam logic signed [18:0] TEMP_LOW_OFS  = 19'sd1500;

endpackage

FILE: hdl/baro_sensor_compensation_core.sv
// barometer compensation core: eight-stage pipeline from raw conversions to
// compensated temperature and pressure; uses baro_comp_pkg and the assert header
//
// Takes one item per clock unless a stall holds the pipeline. Each stage
// holds at most one level of multiplication (the first-order products, then
// the squares of the second-order terms, then the pressure product split in
// two partial products), so throughput is one item per cycle when not stalled.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle. The user must write calibration words
// through the cfg port only while no item is in flight; the core does not check.
`include "baro_sensor_compensation_core_assert.svh"

module baro_sensor_compensation_core
    import baro_comp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic        advance;
    logic [6:0]  stage_valid_reg;
    logic [6:0]  stage_valid_next;
    logic        out_valid_reg;

    // stage 1
    logic signed [24:0] s1_dt_reg, s1_dt_next;
    logic [23:0]        s1_d1_reg;
    // stage 2
    logic signed [41:0] s2_mt_reg, s2_mt_next;
    logic signed [41:0] s2_moff_reg, s2_moff_next;
    logic signed [41:0] s2_msens_reg, s2_msens_next;
    logic signed [49:0] s2_dtsq_reg, s2_dtsq_next;
    logic [23:0]        s2_d1_reg;
    // stage 3
    logic signed [18:0] s3_a_reg, s3_a_next;
    logic signed [18:0] s3_temp_reg, s3_temp_next;
    logic signed [18:0] s3_b_reg, s3_b_next;
    logic               s3_low_reg, s3_low_next;
    logic               s3_vlow_reg, s3_vlow_next;
    logic signed [40:0] s3_off_reg, s3_off_next;
    logic signed [39:0] s3_sens_reg, s3_sens_next;
    logic [17:0]        s3_t2_reg, s3_t2_next;
    logic [23:0]        s3_d1_reg;
    // stage 4
    logic signed [37:0] s4_asq_reg, s4_asq_next;
    logic signed [37:0] s4_bsq_reg, s4_bsq_next;
    logic signed [18:0] s4_temp_reg;
    logic               s4_low_reg;
    logic               s4_vlow_reg;
    logic signed [40:0] s4_off_reg;
    logic signed [39:0] s4_sens_reg;
    logic [17:0]        s4_t2_reg;
    logic [23:0]        s4_d1_reg;
    // stage 5
    logic signed [18:0] s5_temp_reg, s5_temp_next;
    logic signed [40:0] s5_off_reg, s5_off_next;
    logic signed [39:0] s5_sens_reg, s5_sens_next;
    logic [23:0]        s5_d1_reg;
    // stage 6
    logic [43:0]        s6_pplo_reg, s6_pplo_next;
    logic signed [44:0] s6_pphi_reg, s6_pphi_next;
    logic signed [40:0] s6_off_reg;
    logic signed [18:0] s6_temp_reg;
    // stage 7
    logic signed [63:0] s7_prod_reg, s7_prod_next;
    logic signed [40:0] s7_off_reg;
    logic signed [18:0] s7_temp_reg;
    // output
    out_item_t          out_data_reg, out_data_next;

    logic signed [40:0] asq_w, bsq_w, sq5, off2, sens2;
    logic signed [43:0] q;
    logic signed [28:0] p;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stage_valid_next = {stage_valid_reg[5:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SENS_COEF:      c1_reg <= cfg_data;
                CFG_OFF_COEF:       c2_reg <= cfg_data;
                CFG_SENS_TEMP_COEF: c3_reg <= cfg_data;
                CFG_OFF_TEMP_COEF:  c4_reg <= cfg_data;
                CFG_REF_TEMP:       c5_reg <= cfg_data;
                CFG_TEMP_SLOPE:     c6_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= stage_valid_reg[6];
        end
    end

    // stage 1: temperature difference
    assign s1_dt_next = $signed({1'b0, in_data.raw_temperature} - {1'b0, c5_reg, 8'd0});

    // stage 2: first-order products
    assign s2_mt_next    = s1_dt_reg * $signed({1'b0, c6_reg});
    assign s2_moff_next  = s1_dt_reg * $signed({1'b0, c4_reg});
    assign s2_msens_next = s1_dt_reg * $signed({1'b0, c3_reg});
    assign s2_dtsq_next  = s1_dt_reg * s1_dt_reg;

    // stage 3: first-order temperature, offset and sensitivity
    assign s3_a_next    = $signed(s2_mt_reg[41:23]);
    assign s3_temp_next = s3_a_next + TEMP_REF;
    assign s3_low_next  = s3_a_next[18];
    assign s3_vlow_next = s3_temp_next < TEMP_VERY_LOW;
    assign s3_b_next    = s3_temp_next + TEMP_LOW_OFS;
    assign s3_off_next  = $signed({9'd0, c2_reg, 16'd0}) + 41'($signed(s2_moff_reg[41:7]));
    assign s3_sens_next = $signed({9'd0, c1_reg, 15'd0}) + 40'($signed(s2_msens_reg[41:8]));
    assign s3_t2_next   = s2_dtsq_reg[48:31];

    // stage 4: second-order squares
    assign s4_asq_next = s3_a_reg * s3_a_reg;
    assign s4_bsq_next = s3_b_reg * s3_b_reg;

    // stage 5: second-order corrections
    always_comb
    begin
        asq_w = 41'(s4_asq_reg);
        bsq_w = 41'(s4_bsq_reg);
        sq5   = (asq_w <<< 2) + asq_w;
        off2  = 41'sd0;
        sens2 = 41'sd0;
        if (s4_low_reg)
        begin
            off2  = sq5 >>> 1;
            sens2 = sq5 >>> 2;
            if (s4_vlow_reg)
            begin
                off2  = off2 + (bsq_w <<< 3) - bsq_w;
                sens2 = sens2 + (((bsq_w <<< 3) + (bsq_w <<< 1) + bsq_w) >>> 1);
            end
        end
        s5_temp_next = s4_temp_reg - (s4_low_reg ? $signed({1'b0, s4_t2_reg}) : 19'sd0);
        s5_off_next  = s4_off_reg - off2;
        s5_sens_next = s4_sens_reg - 40'(sens2);
    end

    // stage 6: pressure product in two partial products
    assign s6_pplo_next = 44'(s5_d1_reg) * 44'(s5_sens_reg[19:0]);
    assign s6_pphi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[39:20]);

    // stage 7: recombine
    assign s7_prod_next = (64'(s6_pphi_reg) <<< 20) + $signed({20'd0, s6_pplo_reg});

    // stage 8: pressure; p spans 29 bits, so the 32-bit clamp is a sign extension
    always_comb
    begin
        q = 44'($signed(s7_prod_reg[63:21])) - 44'(s7_off_reg);
        p = $signed(q[43:15]);
        out_data_next.temperature       = s7_temp_reg;
        out_data_next.pressure          = 32'(p);
        out_data_next.pressure_negative = p[28];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dt_reg    <= s1_dt_next;
            s1_d1_reg    <= in_data.raw_pressure;

            s2_mt_reg    <= s2_mt_next;
            s2_moff_reg  <= s2_moff_next;
            s2_msens_reg <= s2_msens_next;
            s2_dtsq_reg  <= s2_dtsq_next;
            s2_d1_reg    <= s1_d1_reg;

            s3_a_reg     <= s3_a_next;
            s3_temp_reg  <= s3_temp_next;
            s3_b_reg     <= s3_b_next;
            s3_low_reg   <= s3_low_next;
            s3_vlow_reg  <= s3_vlow_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_t2_reg    <= s3_t2_next;
            s3_d1_reg    <= s2_d1_reg;

            s4_asq_reg   <= s4_asq_next;
            s4_bsq_reg   <= s4_bsq_next;
            s4_temp_reg  <= s3_temp_reg;
            s4_low_reg   <= s3_low_reg;
            s4_vlow_reg  <= s3_vlow_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_t2_reg    <= s3_t2_reg;
            s4_d1_reg    <= s3_d1_reg;

            s5_temp_reg  <= s5_temp_next;
            s5_off_reg   <= s5_off_next;
            s5_sens_reg  <= s5_sens_next;
            s5_d1_reg    <= s4_d1_reg;

            s6_pplo_reg  <= s6_pplo_next;
            s6_pphi_reg  <= s6_pphi_next;
            s6_off_reg   <= s5_off_reg;
            s6_temp_reg  <= s5_temp_reg;

            s7_prod_reg  <= s7_prod_next;
            s7_off_reg   <= s6_off_reg;
            s7_temp_reg  <= s6_temp_reg;

            out_data_reg <= out_data_next;
        end
    end

    `BSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(stage_valid_reg) && out_valid_reg, "stall changed pipeline")
    `BSC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, stage_valid_reg[0], "accepted item lost")
    `BSC_ASSERT_SAME(a_very_low_is_low, clk, rst_n, stage_valid_reg[2] && s3_vlow_reg, s3_low_reg, "very low temperature without low flag")
    `BSC_ASSERT_SAME(a_neg_flag, clk, rst_n, out_valid_reg, out_data_reg.pressure_negative == out_data_reg.pressure[31], "negative flag mismatch")

endmodule

FILE: verif/tb.sv
// self-checking testbench of baro_sensor_compensation_core: directed and random items
// under several calibration settings, each result checked against a built-in predictor
// depends on baro_comp_pkg and the core rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import baro_comp_pkg::*;

    localparam int PIPE_LATENCY = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 65;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam logic signed [63:0] P_MIN = -(64'sd1 <<< 31);
    localparam logic signed [63:0] P_MAX = (64'sd1 <<< 31) - 64'sd1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [15:0] coef [0:5] = '{default: 16'd0};
    out_item_t   comp_q [$];
    logic        idle_en = 1'b1;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          settings_used = 1;

    baro_sensor_compensation_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic out_item_t compensate(input in_item_t it);
        logic signed [63:0] c1, c2, c3, c4, c5, c6;
        logic signed [63:0] d1, d2, dt, temp, off, sens, t2, off2, sens2;
        logic signed [63:0] a, sq, b, sq2, p;
        out_item_t r;
        c1 = {48'd0, coef[CFG_SENS_COEF]};
        c2 = {48'd0, coef[CFG_OFF_COEF]};
        c3 = {48'd0, coef[CFG_SENS_TEMP_COEF]};
        c4 = {48'd0, coef[CFG_OFF_TEMP_COEF]};
        c5 = {48'd0, coef[CFG_REF_TEMP]};
        c6 = {48'd0, coef[CFG_TEMP_SLOPE]};
        d1 = {40'd0, it.raw_pressure};
        d2 = {40'd0, it.raw_temperature};
        dt = d2 - (c5 <<< 8);
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off = (c2 <<< 16) + ((c4 * dt) >>> 7);
        sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
        t2 = '0;
        off2 = '0;
        sens2 = '0;
        // second-order terms below 20 degrees, extra term below -15 degrees
        if (temp < TEMP_REF)
        begin
            a = temp - TEMP_REF;
            sq = 64'sd5 * (a * a);
            t2 = (dt * dt) >>> 31;
            off2 = sq >>> 1;
            sens2 = sq >>> 2;
            if (temp < TEMP_VERY_LOW)
            begin
                b = temp + TEMP_LOW_OFS;
                sq2 = b * b;
                off2 = off2 + 64'sd7 * sq2;
                sens2 = sens2 + ((64'sd11 * sq2) >>> 1);
            end
        end
        temp = temp - t2;
        off = off - off2;
        sens = sens - sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        r.temperature = temp[18:0];
        r.pressure_negative = (p < 0);
        if (p < P_MIN)
            r.pressure = P_MIN[31:0];
        else if (p > P_MAX)
            r.pressure = P_MAX[31:0];
        else
            r.pressure = p[31:0];
        return r;
    endfunction

    function automatic int gap_cycles();
        int n;
        n = 0;
        if (idle_en)
            while ($urandom_range(99) < 35)
                n++;
        return n;
    endfunction

    task automatic send_item(input logic [23:0] raw_t, input logic [23:0] raw_p);
        int gap;
        in_item_t it;
        it.raw_temperature = raw_t;
        it.raw_pressure = raw_p;
        gap = gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        comp_q.push_back(compensate(it));
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (comp_q.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx <= CFG_TEMP_SLOPE)
            coef[idx] = val;
    endtask

    task automatic set_coefs(input logic [15:0] c1, c2, c3, c4, c5, c6);
        drain();
        write_reg(CFG_SENS_COEF, c1);
        write_reg(CFG_OFF_COEF, c2);
        write_reg(CFG_SENS_TEMP_COEF, c3);
        write_reg(CFG_OFF_TEMP_COEF, c4);
        write_reg(CFG_REF_TEMP, c5);
        write_reg(CFG_TEMP_SLOPE, c6);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [23:0] rand_raw_temp();
        int base;
        int v;
        base = int'(coef[CFG_REF_TEMP]) * 256;
        case ($urandom_range(9))
            0, 1, 2, 3: return 24'($urandom_range(24'hFFFFFF));
            8: return 24'h000000;
            9: return 24'hFFFFFF;
            default:
            begin
                // around the reference point, where the 20 degree boundary falls
                v = base + int'($urandom_range(131072)) - 65536;
                if (v < 0)
                    v = 0;
                if (v > 24'hFFFFFF)
                    v = 24'hFFFFFF;
                return 24'(v);
            end
        endcase
    endfunction

    function automatic logic [23:0] rand_raw_press();
        case ($urandom_range(9))
            8: return 24'h000000;
            9: return 24'hFFFFFF;
            default: return 24'($urandom_range(24'hFFFFFF));
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (comp_q.size() == 0)
            begin
                $error("result item with no pending expectation");
                mismatches++;
            end
            else
            begin
                want = comp_q.pop_front();
                if (out_data.temperature !== want.temperature)
                begin
                    $error("temperature: expected %0d, actual %0d",
                           want.temperature, out_data.temperature);
                    mismatches++;
                end
                if (out_data.pressure !== want.pressure)
                begin
                    $error("pressure: expected %0d, actual %0d",
                           want.pressure, out_data.pressure);
                    mismatches++;
                end
                if (out_data.pressure_negative !== want.pressure_negative)
                begin
                    $error("pressure_negative: expected %0b, actual %0b",
                           want.pressure_negative, out_data.pressure_negative);
                    mismatches++;
                end
            end
        end
        out_ready <= !idle_en || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_reset_coefs();
        send_item(24'h000000, 24'h000000);
        send_item(24'hFFFFFF, 24'hFFFFFF);
    endtask

    task automatic test_typical_coefs();
        set_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_item(24'd8569150, 24'd9085466);
        // exactly 20 degrees, then one count below
        send_item({coef[CFG_REF_TEMP], 8'd0}, 24'd9085466);
        send_item({coef[CFG_REF_TEMP], 8'd0} - 24'd1, 24'd9085466);
        // very cold, below -15 degrees
        send_item(24'h000000, 24'd9085466);
        send_item(24'hFFFFFF, 24'h000000);
        send_item(24'h7FFFFF, 24'hFFFFFF);
    endtask

    task automatic test_extreme_coefs();
        set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(24'h000000, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'h000000);
        send_item(24'h000000, 24'h000000);
    endtask

    task automatic test_negative_pressure();
        set_coefs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(24'h123456, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'h000000);
    endtask

    task automatic test_spare_index();
        set_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        @(posedge clk);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hA5A5);
        cfg_write <= 1'b0;
        send_item(24'd8569150, 24'd9085466);
        send_item(24'd2000000, 24'd6000000);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                set_coefs('0, '0, '0, '0, '0, '0);
            else if (ph == 1)
                set_coefs('1, '1, '1, '1, '1, '1);
            else
                set_coefs(rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            // one phase runs back to back on both sides
            idle_en = (ph != 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(rand_raw_temp(), rand_raw_press());
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_coefs();
        test_typical_coefs();
        test_extreme_coefs();
        test_negative_pressure();
        test_spare_index();
        test_random();
        drain();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        $display("%0d items sent under %0d calibration settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("covered reset, typical, extreme and random coefficients, cold and warm inputs");
        if (mismatches == 0 && comp_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
